// ===== sv/ftbp_pkg.sv =====
package ftbp_pkg;

  localparam logic [1:0] CMD_PACKET  = 2'd0;
  localparam logic [1:0] CMD_INSTALL = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] FS_OK     = 2'd0;
  localparam logic [1:0] FS_NOT_IP = 2'd1;

  localparam logic [1:0] MODE_REMOTE = 2'd0;
  localparam logic [1:0] MODE_PASS   = 2'd1;
  localparam logic [1:0] MODE_LIMIT  = 2'd2;

  localparam logic [2:0] V_TX    = 3'd0;
  localparam logic [2:0] V_PASS  = 3'd1;
  localparam logic [2:0] V_DROP  = 3'd2;
  localparam logic [2:0] V_ABORT = 3'd3;
  localparam logic [2:0] V_REDIR = 3'd4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ACT,
    ST_OUT
  } ftbp_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mul;
    logic act;
    logic out_valid;
  } ftbp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ftbp_status_t;

  // one contract as stored in the table RAM
  typedef struct packed {
    logic [103:0] key;
    logic [1:0]   mode;
    logic [31:0]  cap;
    logic [23:0]  rate;
    logic [31:0]  tok;
    logic [31:0]  last;
  } ftbp_entry_t;

endpackage

// ===== sv/ftbp_ctrl.sv =====
module ftbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  out_stall,
  input  ftbp_pkg::ftbp_status_t status,
  output ftbp_pkg::ftbp_cmd_t    ctl
);
  import ftbp_pkg::*;

  ftbp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (status.scan_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACT;
      ST_ACT:  state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      ST_SCAN: ctl.scan = 1'b1;
      ST_MUL:  ctl.mul = 1'b1;
      ST_ACT:  ctl.act = 1'b1;
      ST_OUT:  ctl.out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== sv/ftbp_datapath.sv =====
module ftbp_datapath #(
  parameter int CONTRACTS = 64,
  parameter int QUEUES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ftbp_pkg::ftbp_cmd_t    ctl,
  output ftbp_pkg::ftbp_status_t status,
  input  logic [1:0]  cmd,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic [1:0]  frame_status,
  input  logic [15:0] frame_bytes,
  input  logic [4:0]  rx_queue,
  input  logic [1:0]  contract_mode,
  input  logic [31:0] bucket_capacity,
  input  logic [23:0] token_rate,
  output logic [2:0]  verdict,
  output logic [4:0]  redirect_queue,
  output logic [31:0] tokens_left,
  output logic        install_ok
);
  import ftbp_pkg::*;

  localparam int IW = (CONTRACTS > 1) ? $clog2(CONTRACTS) : 1;
  localparam int CW = $clog2(CONTRACTS + 1);

  // valid bits in flops; contract contents in a RAM read one index per cycle
  logic [CONTRACTS-1:0] vld;

  logic [31:0]  clock_ms;
  logic [1:0]   r_cmd, r_fs;
  logic [103:0] r_key;
  logic [15:0]  r_bytes;
  logic [4:0]   r_q;
  logic [1:0]   r_mode;
  logic [31:0]  r_cap;
  logic [23:0]  r_rate;

  logic [CW-1:0] scan_idx;
  logic [IW-1:0] idx;
  logic          scan_end;
  logic          chk, chk_vld;
  logic [IW-1:0] chk_idx;
  logic          hit, has_free;
  logic [IW-1:0] hit_idx, free_idx, wr_idx;
  ftbp_entry_t   rd_ent, hit_ent, wr_ent;
  logic          match, port_ok, wr_en;

  logic [55:0] product;
  logic [31:0] elapsed, elapsed_c;

  logic [31:0] add_sat, tok_ref, tok_fin;
  logic [32:0] sum;
  logic [18:0] need;
  logic        enough;

  assign idx = scan_idx[IW-1:0];
  // all reads issued; the last read's data is checked as the scan ends
  assign scan_end = (scan_idx == CW'(CONTRACTS));
  assign status.scan_done = scan_end || r_cmd != CMD_INSTALL && r_cmd != CMD_PACKET;

  // read data belongs to the scan index of the previous cycle
  assign match = chk_vld && rd_ent.key == r_key;
  assign port_ok = protocol == PROTO_TCP || protocol == PROTO_UDP;
  assign elapsed_c = clock_ms - hit_ent.last;
  assign wr_idx = hit ? hit_idx : free_idx;

  ftbp_ram #(.WIDTH($bits(ftbp_entry_t)), .DEPTH(CONTRACTS), .AW(IW)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_ent),
    .raddr(idx), .rdata(rd_ent)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_cmd   <= cmd;
      r_fs    <= frame_status;
      r_key   <= {src_addr, dst_addr, port_ok ? src_port : 16'd0,
                  port_ok ? dst_port : 16'd0, protocol};
      r_bytes <= frame_bytes;
      r_q     <= rx_queue;
      r_mode  <= contract_mode;
      r_cap   <= bucket_capacity;
      r_rate  <= token_rate;
      scan_idx <= '0;
      hit <= 1'b0;
      has_free <= 1'b0;
    end
    if (ctl.scan && !status.scan_done) scan_idx <= scan_idx + CW'(1);
    chk     <= ctl.scan && !status.scan_done;
    chk_vld <= vld[idx];
    chk_idx <= idx;
    if (chk) begin
      if (match && !hit) begin
        hit <= 1'b1;
        hit_idx <= chk_idx;
        hit_ent <= rd_ent;
      end
      if (!chk_vld && !has_free) begin
        has_free <= 1'b1;
        free_idx <= chk_idx;
      end
    end
    if (ctl.mul) begin
      elapsed <= elapsed_c;
      product <= 56'(elapsed_c) * 56'(hit_ent.rate);
    end
  end

  // refill / spend arithmetic
  always_comb begin
    add_sat = (product[55:32] != '0) ? 32'hFFFF_FFFF : product[31:0];
    sum = {1'b0, hit_ent.tok} + {1'b0, add_sat};
    tok_ref = hit_ent.tok;
    if (elapsed != '0) tok_ref = (sum > {1'b0, hit_ent.cap}) ? hit_ent.cap : sum[31:0];
    need = {r_bytes, 3'b000};
    enough = tok_ref >= {13'd0, need};
    tok_fin = enough ? tok_ref - {13'd0, need} : tok_ref;
  end

  // table write: a full entry on install, bucket state on a limited packet
  always_comb begin
    wr_en = 1'b0;
    wr_ent = hit_ent;
    wr_ent.tok = tok_fin;
    if (elapsed != '0) wr_ent.last = clock_ms;
    if (ctl.act) begin
      if (r_cmd == CMD_INSTALL) begin
        wr_en = hit || has_free;
        wr_ent = {r_key, r_mode, r_cap, r_rate, r_cap, clock_ms};
      end else if (r_cmd == CMD_PACKET && r_fs == FS_OK && hit &&
                   hit_ent.mode == MODE_LIMIT) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      clock_ms <= '0;
    end else if (ctl.act) begin
      if (r_cmd == CMD_TICK) clock_ms <= clock_ms + 32'd1;
      if (r_cmd == CMD_INSTALL && (hit || has_free)) vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act) begin
      verdict <= V_TX;
      redirect_queue <= '0;
      tokens_left <= '0;
      install_ok <= 1'b0;
      unique case (r_cmd)
        CMD_INSTALL: if (hit || has_free) begin
          install_ok <= 1'b1;
        end
        CMD_PACKET: begin
          if (r_fs == FS_NOT_IP) verdict <= V_TX;
          else if (r_fs != FS_OK) verdict <= V_ABORT;
          else if (!hit) verdict <= V_DROP;
          else begin
            case (hit_ent.mode)
              MODE_REMOTE: if (32'(r_q) < QUEUES) begin
                verdict <= V_REDIR;
                redirect_queue <= r_q;
              end else verdict <= V_DROP;
              MODE_PASS: verdict <= V_PASS;
              MODE_LIMIT: begin
                verdict <= enough ? V_TX : V_DROP;
                tokens_left <= tok_fin;
              end
              default: verdict <= V_DROP;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// generic single-port-write RAM with registered read
module ftbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/flow_token_bucket_policer.sv =====
// Per-flow token bucket policer.
// Packet and install words run a linear key scan, one table RAM read per
// cycle through a registered read port; other words skip the scan.
// One word in flight; the next word is taken in the cycle after the result
// leaves, and a stalled result holds off the next word.
// Reset (rst, synchronous): all entries invalid, clock zero; contents undefined.
module flow_token_bucket_policer #(
  parameter int CONTRACTS = 64,
  parameter int QUEUES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic [1:0]  frame_status,
  input  logic [15:0] frame_bytes,
  input  logic [4:0]  rx_queue,
  input  logic [1:0]  contract_mode,
  input  logic [31:0] bucket_capacity,
  input  logic [23:0] token_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [4:0]  redirect_queue,
  output logic [31:0] tokens_left,
  output logic        install_ok
);
  import ftbp_pkg::*;

  ftbp_cmd_t    ctl;
  ftbp_status_t status;

  // controller sequences load, scan, multiply, act, present
  ftbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .status(status), .ctl(ctl)
  );

  assign out_valid = ctl.out_valid;

  // datapath: key table, clock, refill arithmetic, result registers
  ftbp_datapath #(.CONTRACTS(CONTRACTS), .QUEUES(QUEUES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .status(status),
    .cmd(cmd), .src_addr(src_addr), .dst_addr(dst_addr),
    .src_port(src_port), .dst_port(dst_port), .protocol(protocol),
    .frame_status(frame_status), .frame_bytes(frame_bytes),
    .rx_queue(rx_queue), .contract_mode(contract_mode),
    .bucket_capacity(bucket_capacity), .token_rate(token_rate),
    .verdict(verdict), .redirect_queue(redirect_queue),
    .tokens_left(tokens_left), .install_ok(install_ok)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for flow_token_bucket_policer.
// A scoreboard class models the contract table and the millisecond clock.
// It notes each accepted word and checks each result word against the oldest
// expectation.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ftbp_pkg::*;

  localparam int N_CONTRACTS = 64;
  localparam int N_QUEUES    = 32;
  localparam int WATCHDOG    = 20000;
  localparam int N_RANDOM    = 430;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] FS_TRUNC    = 2'd2;
  localparam logic [1:0] FS_UNKNOWN  = 2'd3;
  localparam logic [1:0] MODE_DROP   = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sa, da;
    logic [15:0] sp, dp;
    logic [7:0]  proto;
    logic [1:0]  fs;
    logic [15:0] bytes;
    logic [4:0]  rxq;
    logic [1:0]  mode;
    logic [31:0] cap;
    logic [23:0] rate;
  } word_t;

  typedef struct {
    logic [2:0]  verdict;
    logic [4:0]  rq;
    logic [31:0] tokens;
    logic        ok;
  } verdict_t;

  class policer_scoreboard;
    bit          valid[N_CONTRACTS];
    logic [63:0] kaddr[N_CONTRACTS];
    logic [39:0] kppp[N_CONTRACTS];
    logic [1:0]  mode[N_CONTRACTS];
    logic [31:0] cap[N_CONTRACTS], tok[N_CONTRACTS], last[N_CONTRACTS];
    logic [23:0] rate[N_CONTRACTS];
    logic [31:0] now_ms;
    verdict_t    pending[$];
    int          errors;

    function void clear();
      foreach (valid[i]) valid[i] = 0;
      now_ms = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int lookup(logic [63:0] a, logic [39:0] p);
      for (int i = 0; i < N_CONTRACTS; i++)
        if (valid[i] && kaddr[i] == a && kppp[i] == p) return i;
      return -1;
    endfunction

    // Refill by elapsed time, then spend 8 tokens per byte if affordable.
    function void police(int e, logic [15:0] bytes, ref verdict_t r);
      logic [31:0] elapsed;
      logic [63:0] add, sum, need;
      logic [31:0] t;
      elapsed = now_ms - last[e];
      t = tok[e];
      if (elapsed != 0) begin
        add = 64'(elapsed) * 64'(rate[e]);
        if (add > 64'hFFFF_FFFF) add = 64'hFFFF_FFFF;
        sum = 64'(t) + add;
        t = (sum > 64'(cap[e])) ? cap[e] : sum[31:0];
        last[e] = now_ms;
      end
      need = 64'(bytes) * 8;
      if (64'(t) >= need) begin
        t = t - need[31:0];
        r.verdict = V_TX;
      end else begin
        r.verdict = V_DROP;
      end
      tok[e] = t;
      r.tokens = t;
    endfunction

    function void note_word(word_t w);
      verdict_t r;
      logic [63:0] a;
      logic [39:0] p;
      int e;
      r = '{V_TX, 5'd0, 32'd0, 1'b0};
      a = {w.sa, w.da};
      // ports only count for TCP and UDP
      if (w.proto == PROTO_TCP || w.proto == PROTO_UDP) p = {w.sp, w.dp, w.proto};
      else p = {32'd0, w.proto};
      case (w.cmd)
        CMD_TICK: now_ms++;
        CMD_INSTALL: begin
          e = lookup(a, p);
          if (e < 0)
            for (int i = 0; i < N_CONTRACTS; i++)
              if (!valid[i]) begin
                e = i;
                break;
              end
          if (e >= 0) begin
            valid[e] = 1; kaddr[e] = a; kppp[e] = p; mode[e] = w.mode;
            cap[e] = w.cap; rate[e] = w.rate; tok[e] = w.cap; last[e] = now_ms;
            r.ok = 1;
          end
        end
        CMD_PACKET: begin
          if (w.fs == FS_NOT_IP) r.verdict = V_TX;
          else if (w.fs != FS_OK) r.verdict = V_ABORT;
          else begin
            e = lookup(a, p);
            if (e < 0) r.verdict = V_DROP;
            else case (mode[e])
              MODE_REMOTE: begin
                if (int'(w.rxq) < N_QUEUES) begin
                  r.verdict = V_REDIR;
                  r.rq = w.rxq;
                end else r.verdict = V_DROP;
              end
              MODE_PASS:  r.verdict = V_PASS;
              MODE_LIMIT: police(e, w.bytes, r);
              default:    r.verdict = V_DROP;
            endcase
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(verdict_t got);
      verdict_t x;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: verdict %0d", $realtime, got.verdict);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.verdict !== x.verdict) begin
        $display("%0t: verdict exp %0d got %0d", $realtime, x.verdict, got.verdict);
        errors++;
      end
      if (got.rq !== x.rq) begin
        $display("%0t: redirect_queue exp %0d got %0d", $realtime, x.rq, got.rq);
        errors++;
      end
      if (got.tokens !== x.tokens) begin
        $display("%0t: tokens_left exp %0d got %0d", $realtime, x.tokens, got.tokens);
        errors++;
      end
      if (got.ok !== x.ok) begin
        $display("%0t: install_ok exp %0d got %0d", $realtime, x.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [31:0] src_addr = '0, dst_addr = '0;
  logic [15:0] src_port = '0, dst_port = '0;
  logic [7:0]  protocol = '0;
  logic [1:0]  frame_status = '0;
  logic [15:0] frame_bytes = '0;
  logic [4:0]  rx_queue = '0;
  logic [1:0]  contract_mode = '0;
  logic [31:0] bucket_capacity = '0;
  logic [23:0] token_rate = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  verdict;
  logic [4:0]  redirect_queue;
  logic [31:0] tokens_left;
  logic        install_ok;

  always #2 clk = ~clk;

  flow_token_bucket_policer #(.CONTRACTS(N_CONTRACTS), .QUEUES(N_QUEUES)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port),
    .dst_port(dst_port), .protocol(protocol), .frame_status(frame_status),
    .frame_bytes(frame_bytes), .rx_queue(rx_queue), .contract_mode(contract_mode),
    .bucket_capacity(bucket_capacity), .token_rate(token_rate),
    .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict),
    .redirect_queue(redirect_queue), .tokens_left(tokens_left),
    .install_ok(install_ok)
  );

  policer_scoreboard sb = new();
  int idle_cycles = 0;

  // Flows sent in install words (not all take once the table is full); packets
  // mostly reuse these keys so that lookups hit and the buckets see real traffic.
  word_t flows[$];

  // Result side: check on accepted edges, stall on its own pattern.
  // Phase 0 never stalls, 1 stalls lightly, 2 stalls heavily.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result('{verdict, redirect_queue, tokens_left, install_ok});
      if ($urandom_range(0, 63) == 0) stall_phase <= int'($urandom_range(0, 2));
      case (stall_phase)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one word and hold it until accepted. Valid stays high on return
  // so that back-to-back words do not drop it in between.
  task automatic send_word(word_t w);
    cmd <= w.cmd; src_addr <= w.sa; dst_addr <= w.da; src_port <= w.sp;
    dst_port <= w.dp; protocol <= w.proto; frame_status <= w.fs;
    frame_bytes <= w.bytes; rx_queue <= w.rxq; contract_mode <= w.mode;
    bucket_capacity <= w.cap; token_rate <= w.rate;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic word_t rand_word();
    word_t w;
    w.cmd = 2'($urandom_range(0, 3));
    w.sa = $urandom; w.da = $urandom; w.sp = 16'($urandom); w.dp = 16'($urandom);
    w.proto = 8'($urandom); w.fs = 2'($urandom_range(0, 3)); w.bytes = 16'($urandom);
    w.rxq = 5'($urandom); w.mode = 2'($urandom); w.cap = $urandom;
    w.rate = 24'($urandom);
    return w;
  endfunction

  function automatic word_t tick_word();
    word_t w;
    w = rand_word();
    w.cmd = CMD_TICK;
    return w;
  endfunction

  // A packet on a known flow, with small frames most of the time.
  function automatic word_t flow_packet();
    word_t w, f;
    w = rand_word();
    f = flows[$urandom_range(0, flows.size() - 1)];
    w.cmd = CMD_PACKET; w.fs = FS_OK;
    w.sa = f.sa; w.da = f.da; w.proto = f.proto;
    if (f.proto == PROTO_TCP || f.proto == PROTO_UDP) begin
      w.sp = f.sp;
      w.dp = f.dp;
    end
    if ($urandom_range(0, 3) != 0) w.bytes = 16'($urandom_range(0, 1500));
    return w;
  endfunction

  function automatic word_t install_word(logic [1:0] m);
    word_t w;
    w = rand_word();
    w.cmd = CMD_INSTALL;
    w.mode = m;
    case ($urandom_range(0, 2))
      0: w.proto = PROTO_TCP;
      1: w.proto = PROTO_UDP;
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      w.cap = $urandom_range(0, 200000);
      w.rate = 24'($urandom_range(0, 20000));
    end
    return w;
  endfunction

  initial begin
    word_t w;
    int burst;
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words.
    w = rand_word(); w.cmd = CMD_PACKET; w.fs = FS_NOT_IP; send_word(w);
    w = rand_word(); w.cmd = CMD_PACKET; w.fs = FS_TRUNC; send_word(w);
    w = rand_word(); w.cmd = CMD_PACKET; w.fs = FS_UNKNOWN; send_word(w);
    w = rand_word(); w.cmd = CMD_PACKET; w.fs = FS_OK; send_word(w);
    w = rand_word(); w.cmd = CMD_UNUSED; send_word(w);
    // Non-TCP/UDP install; packet with different ports must still match.
    w = install_word(MODE_PASS); w.proto = 8'd1; send_word(w); flows.push_back(w);
    w.cmd = CMD_PACKET; w.fs = FS_OK; w.sp = ~w.sp; w.dp = ~w.dp; send_word(w);
    // Remote redirect at queue extremes.
    w = install_word(MODE_REMOTE); w.proto = PROTO_TCP; send_word(w); flows.push_back(w);
    w.cmd = CMD_PACKET; w.fs = FS_OK; w.rxq = 5'd0; send_word(w);
    w.rxq = 5'd31; send_word(w);
    // Drop mode.
    w = install_word(MODE_DROP); send_word(w); flows.push_back(w);
    w.cmd = CMD_PACKET; w.fs = FS_OK; send_word(w);
    // Limit: all-ones capacity, max rate; ticks saturate the refill product.
    w = install_word(MODE_LIMIT); w.proto = PROTO_UDP;
    w.cap = 32'hFFFF_FFFF; w.rate = 24'hFF_FFFF; send_word(w); flows.push_back(w);
    w.cmd = CMD_PACKET; w.fs = FS_OK; w.bytes = 16'hFFFF; send_word(w);
    repeat (300) send_word(tick_word());
    send_word(w);
    // Limit with zero capacity: zero-length passes, one byte drops.
    w = install_word(MODE_LIMIT); w.cap = 0; w.rate = 0; send_word(w); flows.push_back(w);
    w.cmd = CMD_PACKET; w.fs = FS_OK; w.bytes = 0; send_word(w);
    w.bytes = 1; send_word(w);
    // Overwrite an existing key with a new mode.
    w.cmd = CMD_INSTALL; w.mode = MODE_PASS; send_word(w);
    w.cmd = CMD_PACKET; send_word(w);

    // Random part: mostly traffic on known flows, plus ticks, installs
    // (which eventually fill the table) and noise.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            w = install_word(2'($urandom_range(0, 3)));
            send_word(w);
            flows.push_back(w);
          end
          3, 4, 5, 6: send_word(tick_word());
          7, 8: send_word(rand_word());
          default: send_word(flow_packet());
        endcase
      end
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 20));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (N_CONTRACTS + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== flow_token_bucket_policer.f =====
sv/ftbp_pkg.sv
sv/ftbp_ctrl.sv
sv/ftbp_datapath.sv
sv/flow_token_bucket_policer.sv
sim/tb_top.sv
